[src/pbq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pbq_pkg;

    // controller count and field widths
    localparam int PAD_COUNT   = 4;
    localparam int PAD_NUM_W   = 2;
    localparam int BTN_W       = 16;
    localparam int AXIS_W      = 8;
    localparam int TRIG_W      = 8;
    localparam int ANALOG_W    = 10;
    localparam int POLL_CNT_W  = 16;
    localparam int STICK_THR_W = 7;
    localparam int TRIG_THR_W  = 8;
    localparam int DELAY_W     = 8;
    localparam int PERIOD_W    = 4;

    // unchanged-poll counter saturation: jump back by 16 to keep the phase
    localparam logic [POLL_CNT_W-1:0] POLL_CNT_TOP  = 16'hFFFF;
    localparam logic [POLL_CNT_W-1:0] POLL_CNT_WRAP = 16'hFFF0;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_STICK_ON     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_STICK_HOLD   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIG_ON      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_TRIG_HOLD    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_DELAY = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_REPEAT_MASK  = 3'd5;

    // configuration reset values
    localparam logic [STICK_THR_W-1:0] STICK_ON_RESET     = 7'd52;
    localparam logic [STICK_THR_W-1:0] STICK_HOLD_RESET   = 7'd15;
    localparam logic [TRIG_THR_W-1:0]  TRIG_ON_RESET      = 8'd80;
    localparam logic [TRIG_THR_W-1:0]  TRIG_HOLD_RESET    = 8'd40;
    localparam logic [DELAY_W-1:0]     REPEAT_DELAY_RESET = 8'd20;
    localparam logic [PERIOD_W-1:0]    REPEAT_MASK_RESET  = 4'd3;

    // analog bit positions
    localparam int AN_MAIN_X   = 0;
    localparam int AN_MAIN_Y   = 2;
    localparam int AN_SUB_X    = 4;
    localparam int AN_SUB_Y    = 6;
    localparam int AN_TRIG_L   = 8;
    localparam int AN_TRIG_R   = 9;

    typedef struct packed {
        logic [PAD_NUM_W-1:0]     pad_number;
        logic [BTN_W-1:0]         buttons;
        logic signed [AXIS_W-1:0] main_stick_x;
        logic signed [AXIS_W-1:0] main_stick_y;
        logic signed [AXIS_W-1:0] sub_stick_x;
        logic signed [AXIS_W-1:0] sub_stick_y;
        logic [TRIG_W-1:0]        left_trigger;
        logic [TRIG_W-1:0]        right_trigger;
    } poll_t;

    typedef struct packed {
        logic  valid;
        logic  in_range;
        poll_t poll;
    } queue_head_t;

    typedef struct packed {
        logic [STICK_THR_W-1:0] stick_on;
        logic [STICK_THR_W-1:0] stick_hold;
        logic [TRIG_THR_W-1:0]  trig_on;
        logic [TRIG_THR_W-1:0]  trig_hold;
        logic [DELAY_W-1:0]     repeat_delay;
        logic [PERIOD_W-1:0]    repeat_mask;
    } cfg_t;

    typedef struct packed {
        logic [BTN_W-1:0]    held_buttons;
        logic [BTN_W-1:0]    pressed_buttons;
        logic [BTN_W-1:0]    released_buttons;
        logic [BTN_W-1:0]    repeat_buttons;
        logic [ANALOG_W-1:0] analog_held;
        logic [ANALOG_W-1:0] analog_pressed;
        logic [ANALOG_W-1:0] analog_released;
        logic [ANALOG_W-1:0] analog_repeat;
    } result_t;

    // one stick axis with hysteresis: bit 0 low side, bit 1 high side
    function automatic logic [1:0] stick_pair(
        input logic signed [AXIS_W-1:0] pos,
        input logic [1:0]               prev,
        input logic [STICK_THR_W-1:0]   on_thr,
        input logic [STICK_THR_W-1:0]   hold_thr
    );
        logic [STICK_THR_W-1:0]  t_lo;
        logic [STICK_THR_W-1:0]  t_hi;
        logic signed [AXIS_W:0]  pos_ext;
        logic signed [AXIS_W:0]  lo_lim;
        logic signed [AXIS_W:0]  hi_lim;
        logic [1:0]              bits;
        t_lo    = prev[0] ? hold_thr : on_thr;
        t_hi    = prev[1] ? hold_thr : on_thr;
        pos_ext = {pos[AXIS_W-1], pos};
        lo_lim  = -$signed({2'b00, t_lo});
        hi_lim  = $signed({2'b00, t_hi});
        bits[0] = (pos_ext < lo_lim);
        bits[1] = (pos_ext > hi_lim);
        return bits;
    endfunction

    // one trigger with hysteresis
    function automatic logic trigger_bit(
        input logic [TRIG_W-1:0]     level,
        input logic                  prev,
        input logic [TRIG_THR_W-1:0] on_thr,
        input logic [TRIG_THR_W-1:0] hold_thr
    );
        logic [TRIG_THR_W-1:0] t;
        t = prev ? hold_thr : on_thr;
        return (level > t);
    endfunction

endpackage

`default_nettype wire

[src/pbq_channels.sv]
`timescale 1ns / 1ps
`default_nettype none

// poll channel
interface pbq_poll_if;
    logic                              valid;
    logic                              ready;
    logic [pbq_pkg::PAD_NUM_W-1:0]     pad_number;
    logic [pbq_pkg::BTN_W-1:0]         buttons;
    logic signed [pbq_pkg::AXIS_W-1:0] main_stick_x;
    logic signed [pbq_pkg::AXIS_W-1:0] main_stick_y;
    logic signed [pbq_pkg::AXIS_W-1:0] sub_stick_x;
    logic signed [pbq_pkg::AXIS_W-1:0] sub_stick_y;
    logic [pbq_pkg::TRIG_W-1:0]        left_trigger;
    logic [pbq_pkg::TRIG_W-1:0]        right_trigger;

    modport source (
        output valid, pad_number, buttons, main_stick_x, main_stick_y,
               sub_stick_x, sub_stick_y, left_trigger, right_trigger,
        input  ready
    );
    modport sink (
        input  valid, pad_number, buttons, main_stick_x, main_stick_y,
               sub_stick_x, sub_stick_y, left_trigger, right_trigger,
        output ready
    );
endinterface

// result channel
interface pbq_result_if;
    logic                            valid;
    logic                            ready;
    logic [pbq_pkg::BTN_W-1:0]       held_buttons;
    logic [pbq_pkg::BTN_W-1:0]       pressed_buttons;
    logic [pbq_pkg::BTN_W-1:0]       released_buttons;
    logic [pbq_pkg::BTN_W-1:0]       repeat_buttons;
    logic [pbq_pkg::ANALOG_W-1:0]    analog_held;
    logic [pbq_pkg::ANALOG_W-1:0]    analog_pressed;
    logic [pbq_pkg::ANALOG_W-1:0]    analog_released;
    logic [pbq_pkg::ANALOG_W-1:0]    analog_repeat;

    modport source (
        output valid, held_buttons, pressed_buttons, released_buttons, repeat_buttons,
               analog_held, analog_pressed, analog_released, analog_repeat,
        input  ready
    );
    modport sink (
        input  valid, held_buttons, pressed_buttons, released_buttons, repeat_buttons,
               analog_held, analog_pressed, analog_released, analog_repeat,
        output ready
    );
endinterface

`default_nettype wire

[src/pbq_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module pbq_front (
    input  logic                 clk,
    input  logic                 rst_n,
    pbq_poll_if.sink             poll,
    input  logic                 pop,
    output pbq_pkg::queue_head_t head
);

    typedef struct packed {
        logic           in_range;
        pbq_pkg::poll_t poll;
    } entry_t;

    entry_t                           entry_reg [pbq_pkg::QUEUE_DEPTH];
    logic [pbq_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg;
    logic [pbq_pkg::QUEUE_PTR_W-1:0]  wr_ptr_next;
    logic [pbq_pkg::QUEUE_PTR_W-1:0]  rd_ptr_reg;
    logic [pbq_pkg::QUEUE_PTR_W-1:0]  rd_ptr_next;
    logic [pbq_pkg::QUEUE_CNT_W-1:0]  count_reg;
    logic [pbq_pkg::QUEUE_CNT_W-1:0]  count_next;
    logic                             push;
    entry_t                           entry_in;

    localparam logic [pbq_pkg::QUEUE_CNT_W-1:0] QUEUE_FULL =
        pbq_pkg::QUEUE_CNT_W'(pbq_pkg::QUEUE_DEPTH);
    localparam logic [pbq_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        pbq_pkg::QUEUE_PTR_W'(pbq_pkg::QUEUE_DEPTH - 1);

    assign poll.ready = (count_reg != QUEUE_FULL);
    assign push       = poll.valid && poll.ready;

    // classify the incoming poll: controller number in range or not
    always_comb
    begin
        entry_in.poll.pad_number    = poll.pad_number;
        entry_in.poll.buttons       = poll.buttons;
        entry_in.poll.main_stick_x  = poll.main_stick_x;
        entry_in.poll.main_stick_y  = poll.main_stick_y;
        entry_in.poll.sub_stick_x   = poll.sub_stick_x;
        entry_in.poll.sub_stick_y   = poll.sub_stick_y;
        entry_in.poll.left_trigger  = poll.left_trigger;
        entry_in.poll.right_trigger = poll.right_trigger;
        entry_in.in_range = ({{(32 - pbq_pkg::PAD_NUM_W){1'b0}}, poll.pad_number}
                             < 32'(pbq_pkg::PAD_COUNT));
    end

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= entry_in;
        end
    end

    // head of queue toward the back end
    always_comb
    begin
        head.valid    = (count_reg != '0);
        head.in_range = entry_reg[rd_ptr_reg].in_range;
        head.poll     = entry_reg[rd_ptr_reg].poll;
    end

    // checks
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_FULL)
        else $error("queue fill count beyond depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count missed a push");

`default_nettype wire
endmodule

[src/pbq_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module pbq_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pbq_pkg::cfg_t        cfg,
    input  pbq_pkg::queue_head_t head,
    output logic                 pop,
    pbq_result_if.source         result
);

    logic [pbq_pkg::BTN_W-1:0]      prev_btn_reg    [pbq_pkg::PAD_COUNT];
    logic [pbq_pkg::ANALOG_W-1:0]   prev_analog_reg [pbq_pkg::PAD_COUNT];
    logic [pbq_pkg::POLL_CNT_W-1:0] poll_cnt_reg    [pbq_pkg::PAD_COUNT];

    logic [pbq_pkg::BTN_W-1:0]      pb;
    logic [pbq_pkg::ANALOG_W-1:0]   pa;
    logic [pbq_pkg::POLL_CNT_W-1:0] cnt_old;
    logic [pbq_pkg::POLL_CNT_W-1:0] cnt_new;
    logic [pbq_pkg::ANALOG_W-1:0]   ab;
    logic [pbq_pkg::BTN_W-1:0]      btn;
    logic [pbq_pkg::BTN_W-1:0]      b_pr;
    logic [pbq_pkg::ANALOG_W-1:0]   a_pr;
    logic                           rep;
    pbq_pkg::result_t               res_calc;
    pbq_pkg::result_t               res_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;

    // select the state of the polled controller
    always_comb
    begin
        pb      = '0;
        pa      = '0;
        cnt_old = '0;
        for (int i = 0; i < pbq_pkg::PAD_COUNT; i++)
        begin
            if ({{(32 - pbq_pkg::PAD_NUM_W){1'b0}}, head.poll.pad_number} == 32'(i))
            begin
                pb      = prev_btn_reg[i];
                pa      = prev_analog_reg[i];
                cnt_old = poll_cnt_reg[i];
            end
        end
    end

    // analog hysteresis, edges, counter and repeat
    always_comb
    begin
        btn = head.poll.buttons;
        ab[pbq_pkg::AN_MAIN_X +: 2] = pbq_pkg::stick_pair(head.poll.main_stick_x,
            pa[pbq_pkg::AN_MAIN_X +: 2], cfg.stick_on, cfg.stick_hold);
        ab[pbq_pkg::AN_MAIN_Y +: 2] = pbq_pkg::stick_pair(head.poll.main_stick_y,
            pa[pbq_pkg::AN_MAIN_Y +: 2], cfg.stick_on, cfg.stick_hold);
        ab[pbq_pkg::AN_SUB_X +: 2]  = pbq_pkg::stick_pair(head.poll.sub_stick_x,
            pa[pbq_pkg::AN_SUB_X +: 2], cfg.stick_on, cfg.stick_hold);
        ab[pbq_pkg::AN_SUB_Y +: 2]  = pbq_pkg::stick_pair(head.poll.sub_stick_y,
            pa[pbq_pkg::AN_SUB_Y +: 2], cfg.stick_on, cfg.stick_hold);
        ab[pbq_pkg::AN_TRIG_L] = pbq_pkg::trigger_bit(head.poll.left_trigger,
            pa[pbq_pkg::AN_TRIG_L], cfg.trig_on, cfg.trig_hold);
        ab[pbq_pkg::AN_TRIG_R] = pbq_pkg::trigger_bit(head.poll.right_trigger,
            pa[pbq_pkg::AN_TRIG_R], cfg.trig_on, cfg.trig_hold);

        b_pr = btn & ~pb;
        a_pr = ab & ~pa;

        if ((btn == pb) && (ab == pa))
        begin
            cnt_new = (cnt_old == pbq_pkg::POLL_CNT_TOP) ? pbq_pkg::POLL_CNT_WRAP
                                                         : cnt_old + 1'b1;
        end
        else
        begin
            cnt_new = '0;
        end

        rep = (cnt_new >= {{(pbq_pkg::POLL_CNT_W - pbq_pkg::DELAY_W){1'b0}}, cfg.repeat_delay})
              && ((cnt_new[pbq_pkg::PERIOD_W-1:0] & cfg.repeat_mask) == '0);

        res_calc.held_buttons     = btn;
        res_calc.pressed_buttons  = b_pr;
        res_calc.released_buttons = pb & ~btn;
        res_calc.repeat_buttons   = rep ? btn : b_pr;
        res_calc.analog_held      = ab;
        res_calc.analog_pressed   = a_pr;
        res_calc.analog_released  = pa & ~ab;
        res_calc.analog_repeat    = rep ? ab : a_pr;
    end

    // take the queue head when the output register is free or draining
    assign pop            = head.valid && (!out_valid_reg || result.ready);
    assign out_valid_next = pop || (out_valid_reg && !result.ready);

    // per-controller state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pbq_pkg::PAD_COUNT; i++)
            begin
                prev_btn_reg[i]    <= '0;
                prev_analog_reg[i] <= '0;
                poll_cnt_reg[i]    <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop && head.in_range)
            begin
                for (int i = 0; i < pbq_pkg::PAD_COUNT; i++)
                begin
                    if ({{(32 - pbq_pkg::PAD_NUM_W){1'b0}}, head.poll.pad_number}
                        == 32'(i))
                    begin
                        prev_btn_reg[i]    <= btn;
                        prev_analog_reg[i] <= ab;
                        poll_cnt_reg[i]    <= cnt_new;
                    end
                end
            end
        end
    end

    // output register, zero result for a controller out of range
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= head.in_range ? res_calc : '0;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.held_buttons     = res_reg.held_buttons;
    assign result.pressed_buttons  = res_reg.pressed_buttons;
    assign result.released_buttons = res_reg.released_buttons;
    assign result.repeat_buttons   = res_reg.repeat_buttons;
    assign result.analog_held      = res_reg.analog_held;
    assign result.analog_pressed   = res_reg.analog_pressed;
    assign result.analog_released  = res_reg.analog_released;
    assign result.analog_repeat    = res_reg.analog_repeat;

    // checks
    a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((res_reg.pressed_buttons & res_reg.released_buttons) == '0))
        else $error("button pressed and released together");

    a_repeat_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (((res_reg.repeat_buttons & ~res_reg.held_buttons) == '0)
                       && ((res_reg.analog_repeat & ~res_reg.analog_held) == '0)))
        else $error("repeat bit outside held bits");

    a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_valid_reg)
        else $error("popped poll left no result");

`default_nettype wire
endmodule

[src/pad_button_qualifier_core.sv]
// pad_button_qualifier_core: per-controller button edges, analog hysteresis and auto-repeat
//
// poll channel (sink): one transaction per controller poll, carrying the controller
// number, 16 button bits, two signed sticks and two triggers. result channel (source):
// one transaction per poll with held, pressed, released and repeat bits for the buttons
// and for the ten analog direction bits. a poll naming a controller that does not exist
// yields an all-zero result and leaves all state untouched.
// configuration: cfg_write with cfg_index/cfg_data writes one threshold or repeat
// register; write only while no poll is in flight.
// path: an accepted poll waits in the queue until the back end pops it into the result
// register, which it does when that register is free or being drained.
// throughput: one poll per cycle while results are taken, as the back end reads and
// updates the controller state as it pops; a two-entry queue separates poll acceptance
// from result issue. when the receiver stalls the result register holds, the queue
// fills, and poll.ready drops once both queue entries are occupied.
// reset: thresholds return to 52/15 (sticks), 80/40 (triggers), repeat delay 20 and
// period mask 3; all per-controller history and counters clear to zero; the queue
// and result register empty.
`timescale 1ns / 1ps
`default_nettype none

module pad_button_qualifier_core (
    input  logic                              clk,
    input  logic                              rst_n,
    pbq_poll_if.sink                          poll,
    pbq_result_if.source                      result,
    input  logic                              cfg_write,
    input  logic [pbq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pbq_pkg::CFG_DATA_W-1:0]    cfg_data
);

    pbq_pkg::cfg_t        cfg_reg;
    pbq_pkg::cfg_t        cfg_next;
    pbq_pkg::queue_head_t head;
    logic                 pop;

    // configuration register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                pbq_pkg::CFG_STICK_ON:
                    cfg_next.stick_on = cfg_data[pbq_pkg::STICK_THR_W-1:0];
                pbq_pkg::CFG_STICK_HOLD:
                    cfg_next.stick_hold = cfg_data[pbq_pkg::STICK_THR_W-1:0];
                pbq_pkg::CFG_TRIG_ON:
                    cfg_next.trig_on = cfg_data[pbq_pkg::TRIG_THR_W-1:0];
                pbq_pkg::CFG_TRIG_HOLD:
                    cfg_next.trig_hold = cfg_data[pbq_pkg::TRIG_THR_W-1:0];
                pbq_pkg::CFG_REPEAT_DELAY:
                    cfg_next.repeat_delay = cfg_data[pbq_pkg::DELAY_W-1:0];
                pbq_pkg::CFG_REPEAT_MASK:
                    cfg_next.repeat_mask = cfg_data[pbq_pkg::PERIOD_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stick_on     <= pbq_pkg::STICK_ON_RESET;
            cfg_reg.stick_hold   <= pbq_pkg::STICK_HOLD_RESET;
            cfg_reg.trig_on      <= pbq_pkg::TRIG_ON_RESET;
            cfg_reg.trig_hold    <= pbq_pkg::TRIG_HOLD_RESET;
            cfg_reg.repeat_delay <= pbq_pkg::REPEAT_DELAY_RESET;
            cfg_reg.repeat_mask  <= pbq_pkg::REPEAT_MASK_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end: accept and classify polls into the queue
    pbq_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .poll  (poll),
        .pop   (pop),
        .head  (head)
    );

    // back end: state update and result register
    pbq_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

`default_nettype wire
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int IDLE_PCT        = 21;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int LONG_HOLD_RUN   = 40;

    // indexes past the last register, the block must ignore them
    localparam logic [pbq_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [pbq_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_HI = 3'd7;

    logic clk;
    logic rst_n;
    logic cfg_write;
    logic [pbq_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [pbq_pkg::CFG_DATA_W-1:0]  cfg_data;

    pbq_poll_if   poll_ch();
    pbq_result_if result_ch();

    pad_button_qualifier_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .poll      (poll_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the registers and of the per-controller history
    pbq_pkg::cfg_t                  pad_cfg;
    logic [pbq_pkg::BTN_W-1:0]      last_buttons    [pbq_pkg::PAD_COUNT] = '{default: '0};
    logic [pbq_pkg::ANALOG_W-1:0]   last_analog     [pbq_pkg::PAD_COUNT] = '{default: '0};
    logic [pbq_pkg::POLL_CNT_W-1:0] unchanged_polls [pbq_pkg::PAD_COUNT] = '{default: '0};

    pbq_pkg::result_t qualified_due[$];
    int      error_count;
    int      quiet_cycles;
    bit      idle_on;
    bit      hold_off_armed;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // qualify one poll and advance the controller history
    function automatic pbq_pkg::result_t qualify_poll(input pbq_pkg::poll_t p);
        pbq_pkg::result_t                  r;
        logic signed [pbq_pkg::AXIS_W-1:0] axis [4];
        logic [pbq_pkg::TRIG_W-1:0]        trig [2];
        logic [pbq_pkg::BTN_W-1:0]         pb;
        logic [pbq_pkg::ANALOG_W-1:0]      pa;
        logic [pbq_pkg::ANALOG_W-1:0]      an;
        logic [pbq_pkg::POLL_CNT_W-1:0]    cnt;
        logic                              fire;
        int                                lo_t;
        int                                hi_t;
        int                                k;
        r = '0;
        if (int'(p.pad_number) >= pbq_pkg::PAD_COUNT)
            return r;
        pb  = last_buttons[p.pad_number];
        pa  = last_analog[p.pad_number];
        cnt = unchanged_polls[p.pad_number];
        axis[0] = p.main_stick_x;
        axis[1] = p.main_stick_y;
        axis[2] = p.sub_stick_x;
        axis[3] = p.sub_stick_y;
        trig[0] = p.left_trigger;
        trig[1] = p.right_trigger;
        an = '0;
        // stick directions, hold threshold once the bit is already set
        for (k = 0; k < 4; k++)
        begin
            lo_t = pa[2*k]     ? int'(pad_cfg.stick_hold) : int'(pad_cfg.stick_on);
            hi_t = pa[2*k + 1] ? int'(pad_cfg.stick_hold) : int'(pad_cfg.stick_on);
            an[2*k]     = int'(axis[k]) < -lo_t;
            an[2*k + 1] = int'(axis[k]) > hi_t;
        end
        for (k = 0; k < 2; k++)
        begin
            lo_t = pa[pbq_pkg::AN_TRIG_L + k] ? int'(pad_cfg.trig_hold)
                                               : int'(pad_cfg.trig_on);
            an[pbq_pkg::AN_TRIG_L + k] = int'(trig[k]) > lo_t;
        end
        // unchanged-poll counter, jumps back by 16 at the top
        if (p.buttons == pb && an == pa)
            cnt = (cnt == pbq_pkg::POLL_CNT_TOP) ? pbq_pkg::POLL_CNT_WRAP : cnt + 1'b1;
        else
            cnt = '0;
        fire = (cnt >= pad_cfg.repeat_delay) &&
               ((cnt[pbq_pkg::PERIOD_W-1:0] & pad_cfg.repeat_mask) == '0);
        last_buttons[p.pad_number]    = p.buttons;
        last_analog[p.pad_number]     = an;
        unchanged_polls[p.pad_number] = cnt;
        r.held_buttons     = p.buttons;
        r.pressed_buttons  = p.buttons & ~pb;
        r.released_buttons = pb & ~p.buttons;
        r.repeat_buttons   = fire ? p.buttons : r.pressed_buttons;
        r.analog_held      = an;
        r.analog_pressed   = an & ~pa;
        r.analog_released  = pa & ~an;
        r.analog_repeat    = fire ? an : r.analog_pressed;
        return r;
    endfunction

    function automatic pbq_pkg::poll_t poll_of(input int pad, input int btn, input int mx,
                                               input int my, input int sx, input int sy,
                                               input int lt, input int rt);
        pbq_pkg::poll_t p;
        p.pad_number    = pad[pbq_pkg::PAD_NUM_W-1:0];
        p.buttons       = btn[pbq_pkg::BTN_W-1:0];
        p.main_stick_x  = mx[pbq_pkg::AXIS_W-1:0];
        p.main_stick_y  = my[pbq_pkg::AXIS_W-1:0];
        p.sub_stick_x   = sx[pbq_pkg::AXIS_W-1:0];
        p.sub_stick_y   = sy[pbq_pkg::AXIS_W-1:0];
        p.left_trigger  = lt[pbq_pkg::TRIG_W-1:0];
        p.right_trigger = rt[pbq_pkg::TRIG_W-1:0];
        return p;
    endfunction

    // stick value, often just around the current thresholds
    function automatic logic signed [pbq_pkg::AXIS_W-1:0] pick_axis();
        int v;
        case ($urandom_range(3))
            0:       v = int'($urandom_range(255)) - 128;
            1:       v = int'(pad_cfg.stick_on) + int'($urandom_range(2)) - 1;
            2:       v = int'(pad_cfg.stick_hold) + int'($urandom_range(2)) - 1;
            default: v = 127;
        endcase
        if ($urandom_range(1))
            v = -v - (($urandom_range(7) == 0) ? 1 : 0);
        if (v > 127)
            v = 127;
        if (v < -128)
            v = -128;
        return v[pbq_pkg::AXIS_W-1:0];
    endfunction

    function automatic logic [pbq_pkg::TRIG_W-1:0] pick_level();
        int v;
        case ($urandom_range(3))
            0:       v = int'($urandom_range(255));
            1:       v = int'(pad_cfg.trig_on) + int'($urandom_range(2)) - 1;
            2:       v = int'(pad_cfg.trig_hold) + int'($urandom_range(2)) - 1;
            default: v = $urandom_range(1) ? 255 : 0;
        endcase
        if (v > 255)
            v = 255;
        if (v < 0)
            v = 0;
        return v[pbq_pkg::TRIG_W-1:0];
    endfunction

    function automatic pbq_pkg::poll_t pick_poll();
        pbq_pkg::poll_t p;
        p.pad_number = pbq_pkg::PAD_NUM_W'($urandom_range(pbq_pkg::PAD_COUNT - 1));
        case ($urandom_range(3))
            0:       p.buttons = pbq_pkg::BTN_W'($urandom);
            1:       p.buttons = '0;
            2:       p.buttons = '1;
            default: p.buttons = 16'h1 << $urandom_range(pbq_pkg::BTN_W - 1);
        endcase
        p.main_stick_x  = pick_axis();
        p.main_stick_y  = pick_axis();
        p.sub_stick_x   = pick_axis();
        p.sub_stick_y   = pick_axis();
        p.left_trigger  = pick_level();
        p.right_trigger = pick_level();
        return p;
    endfunction

    // offer one poll, predict its result once accepted
    task automatic send_poll(input pbq_pkg::poll_t p);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            @(negedge clk);
            poll_ch.valid <= 1'b0;
        end
        @(negedge clk);
        poll_ch.valid         <= 1'b1;
        poll_ch.pad_number    <= p.pad_number;
        poll_ch.buttons       <= p.buttons;
        poll_ch.main_stick_x  <= p.main_stick_x;
        poll_ch.main_stick_y  <= p.main_stick_y;
        poll_ch.sub_stick_x   <= p.sub_stick_x;
        poll_ch.sub_stick_y   <= p.sub_stick_y;
        poll_ch.left_trigger  <= p.left_trigger;
        poll_ch.right_trigger <= p.right_trigger;
        do
            @(posedge clk);
        while (!poll_ch.ready);
        qualified_due.push_back(qualify_poll(p));
    endtask

    // stop offering and wait for every outstanding result
    task automatic wait_drained();
        @(negedge clk);
        poll_ch.valid <= 1'b0;
        while (qualified_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_cfg(input logic [pbq_pkg::CFG_INDEX_W-1:0] index,
                             input logic [pbq_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (index)
            pbq_pkg::CFG_STICK_ON:
                pad_cfg.stick_on = data[pbq_pkg::STICK_THR_W-1:0];
            pbq_pkg::CFG_STICK_HOLD:
                pad_cfg.stick_hold = data[pbq_pkg::STICK_THR_W-1:0];
            pbq_pkg::CFG_TRIG_ON:
                pad_cfg.trig_on = data[pbq_pkg::TRIG_THR_W-1:0];
            pbq_pkg::CFG_TRIG_HOLD:
                pad_cfg.trig_hold = data[pbq_pkg::TRIG_THR_W-1:0];
            pbq_pkg::CFG_REPEAT_DELAY:
                pad_cfg.repeat_delay = data[pbq_pkg::DELAY_W-1:0];
            pbq_pkg::CFG_REPEAT_MASK:
                pad_cfg.repeat_mask = data[pbq_pkg::PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [7:0] stick_on, input logic [7:0] stick_hold,
                                  input logic [7:0] trig_on, input logic [7:0] trig_hold,
                                  input logic [7:0] delay, input logic [7:0] mask);
        wait_drained();
        write_cfg(pbq_pkg::CFG_STICK_ON, stick_on);
        write_cfg(pbq_pkg::CFG_STICK_HOLD, stick_hold);
        write_cfg(pbq_pkg::CFG_TRIG_ON, trig_on);
        write_cfg(pbq_pkg::CFG_TRIG_HOLD, trig_hold);
        write_cfg(pbq_pkg::CFG_REPEAT_DELAY, delay);
        write_cfg(pbq_pkg::CFG_REPEAT_MASK, mask);
    endtask

    // mostly runs of repeated polls so the repeat counter gets going, with tweaks
    task automatic run_random_polls(input int n);
        pbq_pkg::poll_t p;
        int    left;
        int    run;
        left = n;
        while (left > 0)
        begin
            p = pick_poll();
            if ($urandom_range(99) < 60)
                run = $urandom_range(1, int'(pad_cfg.repeat_delay) + 10);
            else
                run = 1;
            if (run > left)
                run = left;
            repeat (run)
            begin
                if ($urandom_range(99) < 6)
                begin
                    p.main_stick_x  = pick_axis();
                    p.sub_stick_y   = pick_axis();
                    p.right_trigger = pick_level();
                end
                if ($urandom_range(99) < 3)
                    p.buttons[$urandom_range(pbq_pkg::BTN_W - 1)] ^= 1'b1;
                send_poll(p);
                left--;
            end
        end
    endtask

    // edges of the digital buttons, extremes of every field
    task automatic test_button_edges();
        send_poll(poll_of(0, 16'h0000, 0, 0, 0, 0, 0, 0));
        send_poll(poll_of(0, 16'hFFFF, -128, 127, 127, -128, 255, 255));
        send_poll(poll_of(0, 16'h0000, 127, -128, -128, 127, 0, 0));
        send_poll(poll_of(1, 16'hA5A5, 0, 0, 0, 0, 0, 0));
        send_poll(poll_of(1, 16'h5A5A, 0, 0, 0, 0, 0, 0));
        send_poll(poll_of(2, 16'h0001, 0, 0, 0, 0, 0, 0));
        send_poll(poll_of(3, 16'h8000, 0, 0, 0, 0, 0, 0));
        send_poll(poll_of(3, 16'h8000, 0, 0, 0, 0, 0, 0));
    endtask

    // set above the on threshold, keep above the hold threshold, both signs
    task automatic test_analog_hysteresis();
        int stick_seq [11] = '{52, 53, 16, 15, 53, -53, -16, -15, 127, -127, 0};
        int level_seq [11] = '{80, 81, 41, 40, 255, 81, 41, 40, 0, 255, 0};
        int k;
        for (k = 0; k < 11; k++)
            send_poll(poll_of(2, 0, stick_seq[k], -stick_seq[k], -stick_seq[k],
                              stick_seq[k], level_seq[k], level_seq[k]));
    endtask

    // writes past the last register change nothing
    task automatic test_unused_cfg_index();
        wait_drained();
        write_cfg(CFG_UNUSED_LO, 8'h00);
        write_cfg(CFG_UNUSED_HI, 8'h00);
        send_poll(poll_of(0, 16'h0F0F, 30, -30, 30, -30, 60, 60));
        send_poll(poll_of(0, 16'h0F0F, 53, -53, 53, -53, 81, 81));
        send_poll(poll_of(0, 16'h0F0F, 30, -30, 30, -30, 60, 60));
    endtask

    // receiver holds off while polls keep coming, then the sender waits it out
    task automatic test_backpressure();
        hold_off_armed = 1'b1;
        repeat (24) send_poll(pick_poll());
        wait_drained();
    endtask

    task automatic test_default_settings();
        run_random_polls(150);
    endtask

    task automatic test_zero_settings();
        apply_settings(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
        run_random_polls(120);
    endtask

    // upper data bits of the narrow registers are dropped
    task automatic test_max_settings();
        apply_settings(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        run_random_polls(120);
    endtask

    task automatic test_inverted_hysteresis();
        apply_settings(8'd10, 8'd100, 8'd30, 8'd200, 8'd3, 8'd1);
        run_random_polls(120);
    endtask

    // one controller held still over several repeat periods, then released
    task automatic test_long_hold();
        apply_settings(8'd52, 8'd15, 8'd80, 8'd40, 8'd0, 8'd15);
        repeat (LONG_HOLD_RUN) send_poll(poll_of(3, 16'h8001, 100, -100, 0, 60, 200, 0));
        send_poll(poll_of(3, 16'h8000, 100, -100, 0, 60, 200, 0));
    endtask

    // random register values, no idling on either side
    task automatic test_random_settings();
        apply_settings(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom));
        idle_on = 1'b0;
        run_random_polls(150);
        wait_drained();
        idle_on = 1'b1;
    endtask

    // receiver: random stalls, or one long hold-off when armed
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_armed)
            begin
                hold_off_armed = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
            end
            else
                result_ch.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
            error_count++;
        end
    endtask

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        pbq_pkg::result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (qualified_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual held %0h",
                         $time, result_ch.held_buttons);
                error_count++;
            end
            else
            begin
                want = qualified_due.pop_front();
                check_field("held_buttons", want.held_buttons, result_ch.held_buttons);
                check_field("pressed_buttons", want.pressed_buttons,
                            result_ch.pressed_buttons);
                check_field("released_buttons", want.released_buttons,
                            result_ch.released_buttons);
                check_field("repeat_buttons", want.repeat_buttons, result_ch.repeat_buttons);
                check_field("analog_held", want.analog_held, result_ch.analog_held);
                check_field("analog_pressed", want.analog_pressed, result_ch.analog_pressed);
                check_field("analog_released", want.analog_released,
                            result_ch.analog_released);
                check_field("analog_repeat", want.analog_repeat, result_ch.analog_repeat);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((poll_ch.valid && poll_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n                 = 1'b0;
        cfg_write             = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        poll_ch.valid         = 1'b0;
        poll_ch.pad_number    = '0;
        poll_ch.buttons       = '0;
        poll_ch.main_stick_x  = '0;
        poll_ch.main_stick_y  = '0;
        poll_ch.sub_stick_x   = '0;
        poll_ch.sub_stick_y   = '0;
        poll_ch.left_trigger  = '0;
        poll_ch.right_trigger = '0;
        pad_cfg = '{pbq_pkg::STICK_ON_RESET, pbq_pkg::STICK_HOLD_RESET,
                    pbq_pkg::TRIG_ON_RESET, pbq_pkg::TRIG_HOLD_RESET,
                    pbq_pkg::REPEAT_DELAY_RESET, pbq_pkg::REPEAT_MASK_RESET};
        error_count    = 0;
        quiet_cycles   = 0;
        idle_on        = 1'b1;
        hold_off_armed = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_button_edges();
        test_analog_hysteresis();
        test_unused_cfg_index();
        test_backpressure();
        test_default_settings();
        test_zero_settings();
        test_max_settings();
        test_inverted_hysteresis();
        test_long_hold();
        test_random_settings();
        wait_drained();

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
